/* rtl/core/center_crop_gray_converter_defines.svh */
// ----------------------------------------------------------------------------
// center_crop_gray_converter_defines.svh
// Assertion macros shared by the crop and gray converter RTL.
// ----------------------------------------------------------------------------
`ifndef CENTER_CROP_GRAY_CONVERTER_DEFINES_SVH
`define CENTER_CROP_GRAY_CONVERTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define CCG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger
`define CCG_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ccg_pkg.sv */
// ----------------------------------------------------------------------------
// ccg_pkg
// Types, register codes and gray conversion constants for the center crop
// gray converter.
// ----------------------------------------------------------------------------
package ccg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_CROP_EDGE    = 2'd2,
        REG_PIXEL_FORMAT = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 12'd400;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 12'd296;
    localparam logic [CFG_DATA_W-1:0] RST_CROP_EDGE    = 12'd96;
    localparam logic                  RST_PIXEL_FORMAT = 1'b1;

    // Pixel formats
    localparam logic FMT_GRAY   = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    // Gray weighting: (30 r + 59 g + 11 b) / 100, sum fits 15 bits (max 25036)
    localparam int SUM_W = 15;
    localparam logic [SUM_W-1:0] W_RED   = 15'd30;
    localparam logic [SUM_W-1:0] W_GREEN = 15'd59;
    localparam logic [SUM_W-1:0] W_BLUE  = 15'd11;
    localparam int GRAY_DIV = 100;

    // Divide by 100 as multiply by ceil(2^19/100), exact for sums below 43690
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((1 << RECIP_SHIFT) + GRAY_DIV - 1) / GRAY_DIV);
    localparam int PROD_W = SUM_W + RECIP_W;

    // Channel masks
    localparam logic [4:0] MASK5 = 5'h1F;
    localparam logic [5:0] MASK6 = 6'h3F;

    // Request payloads
    typedef struct packed {
        logic [15:0] pixel_word;
        logic        frame_first;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] gray_level;
        logic       crop_last;
        logic       crop_error;
    } gray_out_t;

    // Window decision for one pixel
    typedef struct packed {
        logic emit;
        logic last;
        logic err;
    } win_t;

    // Weighted channel sum of one RGB565 word, channels widened to 8 bits
    function automatic logic [SUM_W-1:0] rgb_weight_sum(input logic [15:0] word);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r8 = {word[15:11] & MASK5, 3'b000};
        g8 = {word[10:5] & MASK6, 2'b00};
        b8 = {word[4:0] & MASK5, 3'b000};
        return SUM_W'(r8) * W_RED + SUM_W'(g8) * W_GREEN + SUM_W'(b8) * W_BLUE;
    endfunction

endpackage

/* rtl/core/ccg_window.sv */
// ----------------------------------------------------------------------------
// ccg_window
// Column and row counters and the centered crop window decision.
// ----------------------------------------------------------------------------
module ccg_window import ccg_pkg::*; #(
    parameter int MAX_DIM = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  first,
    input  logic [CFG_DATA_W-1:0] frame_width,
    input  logic [CFG_DATA_W-1:0] frame_height,
    input  logic [CFG_DATA_W-1:0] crop_edge,
    output win_t                  win
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int EXT_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;

    logic [EXT_W-1:0] w_ext, h_ext, c_ext;
    logic [DIM_W-1:0] w, h, c;
    logic [DIM_W-1:0] col, row;
    logic [DIM_W-1:0] sx, sy, ex, ey;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             err, in_window;

    // Effective dimensions: zero or oversize maps to MAX_DIM, crop capped
    always_comb
    begin
        w_ext = EXT_W'(frame_width);
        h_ext = EXT_W'(frame_height);
        c_ext = EXT_W'(crop_edge);
        w = (w_ext == '0 || w_ext > MAX_EXT) ? DIM_W'(MAX_DIM) : DIM_W'(w_ext);
        h = (h_ext == '0 || h_ext > MAX_EXT) ? DIM_W'(MAX_DIM) : DIM_W'(h_ext);
        c = (c_ext > MAX_EXT) ? DIM_W'(MAX_DIM) : DIM_W'(c_ext);
    end

    // Position of this pixel; first mark forces the origin
    assign col = first ? '0 : DIM_W'(col_reg);
    assign row = first ? '0 : DIM_W'(row_reg);

    // Window bounds, valid only when the crop fits
    assign err       = (c > w) || (c > h);
    assign sx        = (w - c) >> 1;
    assign sy        = (h - c) >> 1;
    assign ex        = sx + c;
    assign ey        = sy + c;
    assign in_window = (col >= sx) && (col < ex) && (row >= sy) && (row < ey);

    always_comb
    begin
        win.err  = err;
        win.emit = err || ((c != '0) && in_window);
        win.last = !err && (col == ex - 1'b1) && (row == ey - 1'b1);
    end

    // Raster advance with wrap at the effective frame size
    assign col_inc = col + 1'b1;
    assign row_inc = row + 1'b1;

    always_comb
    begin
        if (col_inc >= w)
        begin
            col_next = '0;
            row_next = (row_inc >= h) ? '0 : CNT_W'(row_inc);
        end
        else
        begin
            col_next = CNT_W'(col_inc);
            row_next = CNT_W'(row);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/center_crop_gray_converter.sv */
// ----------------------------------------------------------------------------
// center_crop_gray_converter
// Crops a centered square out of a raster pixel stream and emits 8-bit gray.
//
//   channel  direction  handshake                 payload
//   pixel    in         pixel_valid / pixel_stall pix_in_t   (word, first)
//   gray     out        gray_valid / gray_stall   gray_out_t (level, last, err)
//   cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One pixel is accepted every cycle while pixel_stall is low; each result passes
// the window/sum stage and then the divide-by-100 output stage.
// Pixels outside the window leave the pipe without a result.
// Reset clears the counters, stage valids and loads the register defaults;
// no clearing pass. A gray stall holds the output register; pixel_stall
// rises only when both stages are full and the output is stalled.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "center_crop_gray_converter_defines.svh"

module center_crop_gray_converter import ccg_pkg::*; #(
    parameter int MAX_DIM = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pix_in_t               pixel,
    output logic                  gray_valid,
    input  logic                  gray_stall,
    output gray_out_t             gray,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;
    logic [CFG_DATA_W-1:0] crop_edge_reg;
    logic                  pixel_format_reg;

    // Stage 1: window decision and weighted sum
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_err_reg;
    logic             s1_rgb_reg;
    logic [SUM_W-1:0] s1_value_reg;

    // Stage 2: output register
    logic      out_valid_reg, out_valid_next;
    gray_out_t out_reg;

    logic              s1_load, s2_load;
    logic              cfg_write;
    win_t              win;
    logic [PROD_W-1:0] prod;
    logic [7:0]        level;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            crop_edge_reg    <= RST_CROP_EDGE;
            pixel_format_reg <= RST_PIXEL_FORMAT;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_CROP_EDGE:    crop_edge_reg    <= cfg_data;
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Pipeline flow
    assign s2_load     = !out_valid_reg || !gray_stall;
    assign pixel_stall = s1_valid_reg && !s2_load;
    assign s1_load     = pixel_valid && !pixel_stall;

    // Counters and window
    ccg_window #(
        .MAX_DIM (MAX_DIM)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (s1_load),
        .first        (pixel.frame_first),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .crop_edge    (crop_edge_reg),
        .win          (win)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_emit_reg <= win.emit;
            s1_last_reg <= win.last;
            s1_err_reg  <= win.err;
            if (win.err)
            begin
                s1_rgb_reg   <= FMT_GRAY;
                s1_value_reg <= '0;
            end
            else if (pixel_format_reg == FMT_RGB565)
            begin
                s1_rgb_reg   <= FMT_RGB565;
                s1_value_reg <= rgb_weight_sum(pixel.pixel_word);
            end
            else
            begin
                s1_rgb_reg   <= FMT_GRAY;
                s1_value_reg <= SUM_W'(pixel.pixel_word[7:0]);
            end
        end
    end

    // Stage 2: divide by 100 through the reciprocal for RGB565 sums; gray passes through
    assign prod  = PROD_W'(s1_value_reg) * PROD_W'(RECIP_MUL);
    assign level = s1_rgb_reg ? prod[RECIP_SHIFT +: 8] : s1_value_reg[7:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_load)
            out_valid_next = s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            out_reg.gray_level <= level;
            out_reg.crop_last  <= s1_last_reg;
            out_reg.crop_error <= s1_err_reg;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign gray_valid = out_valid_reg;
    assign gray       = out_reg;

    // Checks
    `CCG_ASSERT_ALWAYS(a_err_clean,
        !(gray_valid && gray.crop_error) || (gray.gray_level == 8'd0 && !gray.crop_last),
        "error result carries gray or last")
    `CCG_ASSERT_ALWAYS(a_stall_full, !pixel_stall || s1_valid_reg,
        "pixel stall with stage 1 empty")
    `CCG_ASSERT_NEXT(a_emit_moves, s2_load && s1_valid_reg && s1_emit_reg, gray_valid,
        "emitting pixel lost between stages")
    `CCG_ASSERT_NEXT(a_drop_silent, s2_load && !(s1_valid_reg && s1_emit_reg), !gray_valid,
        "result invented for a pixel outside the window")

endmodule
